[rtl/lcsr_pkg.sv]
// Shared constants and types for the load-cell converter serial readout block.
package lcsr_pkg;

   // Default sample width of the converter.
   localparam int DATA_BITS_DEF = 24;

   // Widths fixed by the result and configuration fields.
   localparam int RAW_W    = 24;
   localparam int WEIGHT_W = 16;
   localparam int TIMER_W  = 24;
   localparam int HALF_W   = 8;
   localparam int EXTRA_W  = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 24;

   // Configuration register values after reset.
   localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 24'd1000000;
   localparam logic [HALF_W-1:0]  HALF_RESET    = 8'd1;
   localparam logic [EXTRA_W-1:0] EXTRA_RESET   = 2'd1;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_READY_TIMEOUT = 2'd0,
      CSR_HALF_PERIOD   = 2'd1,
      CSR_EXTRA_PULSES  = 2'd2
   } csr_index_type;

   // Requested action codes; the unused code behaves as a plain tick.
   typedef enum logic [1:0] {
      ACT_TICK    = 2'd0,
      ACT_MEASURE = 2'd1,
      ACT_TARE    = 2'd2
   } action_type;

   // Division by 1000 as a multiply by a rounded-up reciprocal. The rounding
   // error times the largest 24-bit magnitude stays below 2**DIV_SHIFT, so the
   // truncated product equals the true quotient.
   localparam int  GRAM_DIVISOR = 1000;
   localparam int  DIV_SHIFT    = 34;
   localparam longint DIV_MULT_L = ((64'd1 << DIV_SHIFT) + GRAM_DIVISOR - 1) / GRAM_DIVISOR;
   localparam int  DIV_MULT_W   = 25;
   localparam logic [DIV_MULT_W-1:0] DIV_MULT = DIV_MULT_W'(DIV_MULT_L);
   localparam int  PROD_W       = RAW_W + DIV_MULT_W;
   localparam int  QUOT_W       = PROD_W - DIV_SHIFT;

   // Saturation limits of the raw sample.
   localparam logic signed [32:0] RAW_MAX = 33'sd8388607;
   localparam logic signed [32:0] RAW_MIN = -33'sd8388608;

endpackage

[rtl/load_cell_adc_serial_reader.sv]
// Load-cell converter serial readout sequencer with tare offset and gram scaling.
//
//  Channel | Direction | Handshake             | Payload
//  --------+-----------+-----------------------+-------------------------------------------
//  req     | in        | req_valid / req_stall | action, dout_level (one tick per transfer)
//  rsp     | out       | rsp_valid / rsp_stall | sck_level, busy/done/status, raw, weight
//  csr     | in        | csr_valid / csr_ready | csr_index, csr_wdata
//
// One tick is taken every cycle while req_stall is low; its result is in the output register on the next cycle.
// The sequencer state advances only on a req transfer, so the pin timing counts ticks.
// The gram scaling is one 24 x 25 multiply inside that same register-to-register path.
// req_stall is high during reset and while a result waits and rsp_stall holds it back.
// Synchronous reset clears the sequencer and the tare offset and restores the
// configuration defaults; csr_ready is low during reset.
module load_cell_adc_serial_reader #(
   parameter int DATA_BITS = lcsr_pkg::DATA_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_action,
   input  logic                                  req_dout_level,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_sck_level,
   output logic                                  rsp_busy_res,
   output logic                                  rsp_done_res,
   output logic                                  rsp_timed_out,
   output logic                                  rsp_was_tare,
   output logic signed [lcsr_pkg::RAW_W-1:0]     rsp_raw_value,
   output logic signed [lcsr_pkg::WEIGHT_W-1:0]  rsp_weight_grams,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [lcsr_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [lcsr_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import lcsr_pkg::*;

   localparam int BITS_W = $clog2(DATA_BITS + 4);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_WAIT,
      PH_HIGH,
      PH_LOW
   } phase_type;

   // Configuration.
   logic [TIMER_W-1:0] timeout_ff;
   logic [HALF_W-1:0]  half_ff;
   logic [EXTRA_W-1:0] extra_ff;

   // Sequencer state.
   phase_type              phase_ff, phase_in;
   logic [TIMER_W-1:0]     timer_ff, timer_in;
   logic [BITS_W-1:0]      bits_ff, bits_in;
   logic [DATA_BITS-1:0]   shift_ff, shift_in;
   logic signed [RAW_W-1:0] tare_ff, tare_in;
   logic                   pend_ff, pend_in;

   // Result register.
   logic                    rsp_valid_ff;
   logic                    sck_ff, sck_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic                    tout_ff, tout_in;
   logic                    wtare_ff, wtare_in;
   logic signed [RAW_W-1:0]    raw_ff, raw_in;
   logic signed [WEIGHT_W-1:0] weight_ff, weight_in;

   logic                    req_take;
   logic                    finish;
   logic                    from_sample;
   logic [TIMER_W-1:0]      timer_inc;
   logic [TIMER_W-1:0]      half_ext;
   logic [BITS_W-1:0]       bits_inc;
   logic [BITS_W-1:0]       bits_total;
   logic signed [32:0]      sample_ext;
   logic signed [RAW_W-1:0] sample_raw;
   logic signed [RAW_W:0]   diff;
   logic [RAW_W-1:0]        diff_mag;
   logic [PROD_W-1:0]       prod;
   logic [QUOT_W-1:0]       quot;
   logic [WEIGHT_W-1:0]     quot_ext;

   assign req_stall = reset || (rsp_valid_ff && rsp_stall);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = !reset;

   assign timer_inc  = timer_ff + 1'b1;
   assign half_ext   = TIMER_W'(half_ff);
   assign bits_inc   = bits_ff + 1'b1;
   assign bits_total = BITS_W'(DATA_BITS) + BITS_W'(extra_ff);

   // Sign-extend the shifted sample and clamp it to the 24-bit result range.
   assign sample_ext = 33'($signed(shift_in));
   always_comb begin
      if (sample_ext > RAW_MAX) begin
         sample_raw = RAW_MAX[RAW_W-1:0];
      end else if (sample_ext < RAW_MIN) begin
         sample_raw = RAW_MIN[RAW_W-1:0];
      end else begin
         sample_raw = sample_ext[RAW_W-1:0];
      end
   end

   // Gram scaling: divide the magnitude, then restore the sign (truncation toward zero).
   assign diff     = {raw_in[RAW_W-1], raw_in} - {tare_ff[RAW_W-1], tare_ff};
   assign diff_mag = diff[RAW_W] ? RAW_W'(-diff) : diff[RAW_W-1:0];
   assign prod     = PROD_W'(diff_mag) * PROD_W'(DIV_MULT);
   assign quot     = prod[PROD_W-1:DIV_SHIFT];
   assign quot_ext = WEIGHT_W'(quot);

   always_comb begin
      phase_in    = phase_ff;
      timer_in    = timer_ff;
      bits_in     = bits_ff;
      shift_in    = shift_ff;
      pend_in     = pend_ff;
      tare_in     = tare_ff;
      sck_in      = 1'b0;
      finish      = 1'b0;
      from_sample = 1'b0;
      tout_in     = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (req_action == ACT_MEASURE || req_action == ACT_TARE) begin
               phase_in = PH_WAIT;
               timer_in = '0;
               pend_in  = (req_action == ACT_TARE);
            end
         end
         PH_WAIT: begin
            if (!req_dout_level) begin
               phase_in = PH_HIGH;
               timer_in = TIMER_W'(1);
               bits_in  = '0;
               shift_in = '0;
               sck_in   = 1'b1;
            end else begin
               timer_in = timer_inc;
               if (timer_inc >= timeout_ff) begin
                  finish  = 1'b1;
                  tout_in = 1'b1;
               end
            end
         end
         PH_HIGH: begin
            if (timer_ff >= half_ext) begin
               phase_in = PH_LOW;
               timer_in = TIMER_W'(1);
            end else begin
               timer_in = timer_inc;
               sck_in   = 1'b1;
            end
         end
         PH_LOW: begin
            if (timer_ff >= half_ext) begin
               // Data bits are sampled at the end of the low half; gain pulses are not.
               if (bits_ff < BITS_W'(DATA_BITS)) begin
                  shift_in = {shift_ff[DATA_BITS-2:0], req_dout_level};
               end
               bits_in = bits_inc;
               if (bits_inc >= bits_total) begin
                  finish      = 1'b1;
                  from_sample = 1'b1;
               end else begin
                  phase_in = PH_HIGH;
                  timer_in = TIMER_W'(1);
                  sck_in   = 1'b1;
               end
            end else begin
               timer_in = timer_inc;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      raw_in    = from_sample ? sample_raw : '0;
      wtare_in  = 1'b0;
      weight_in = '0;
      if (finish) begin
         sck_in   = 1'b0;
         phase_in = PH_IDLE;
         timer_in = '0;
         bits_in  = '0;
         pend_in  = 1'b0;
         if (pend_ff) begin
            wtare_in = 1'b1;
            tare_in  = raw_in;
         end else begin
            weight_in = diff[RAW_W] ? -quot_ext : quot_ext;
         end
      end
      done_in = finish;
      busy_in = (phase_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= TIMEOUT_RESET;
         half_ff      <= HALF_RESET;
         extra_ff     <= EXTRA_RESET;
         phase_ff     <= PH_IDLE;
         timer_ff     <= '0;
         bits_ff      <= '0;
         shift_ff     <= '0;
         tare_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sck_ff       <= 1'b0;
         busy_ff      <= 1'b0;
         done_ff      <= 1'b0;
         tout_ff      <= 1'b0;
         wtare_ff     <= 1'b0;
         raw_ff       <= '0;
         weight_ff    <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_READY_TIMEOUT: timeout_ff <= TIMER_W'(csr_wdata);
               CSR_HALF_PERIOD:   half_ff    <= csr_wdata[HALF_W-1:0];
               CSR_EXTRA_PULSES:  extra_ff   <= csr_wdata[EXTRA_W-1:0];
               default: begin
               end
            endcase
         end
         if (req_take) begin
            phase_ff     <= phase_in;
            timer_ff     <= timer_in;
            bits_ff      <= bits_in;
            shift_ff     <= shift_in;
            tare_ff      <= tare_in;
            pend_ff      <= pend_in;
            rsp_valid_ff <= 1'b1;
            sck_ff       <= sck_in;
            busy_ff      <= busy_in;
            done_ff      <= done_in;
            tout_ff      <= tout_in;
            wtare_ff     <= wtare_in;
            raw_ff       <= raw_in;
            weight_ff    <= weight_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sck_level    = sck_ff;
   assign rsp_busy_res     = busy_ff;
   assign rsp_done_res     = done_ff;
   assign rsp_timed_out    = tout_ff;
   assign rsp_was_tare     = wtare_ff;
   assign rsp_raw_value    = raw_ff;
   assign rsp_weight_grams = weight_ff;

`ifndef SYNTHESIS
   // A finished readout always returns the sequencer to idle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && done_ff |-> !busy_ff && phase_ff == PH_IDLE)
      else $error("done reported while the sequencer is still busy");

   // Status flags only appear together with done.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (tout_ff || wtare_ff) |-> done_ff)
      else $error("timeout or tare flag without done");

   // A tare readout reports no weight.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && wtare_ff |-> weight_ff == '0)
      else $error("tare readout reported a nonzero weight");

   // The serial clock is only driven high during a readout.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && sck_ff |-> busy_ff)
      else $error("serial clock high while idle");

   // The idle sequencer holds cleared counters.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> bits_ff == '0 && !pend_ff)
      else $error("idle sequencer with stale bit count or pending tare");
`endif

endmodule
